FILE: hdl/lspfc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lspfc_pkg;

    // Default sizes of the sieve
    localparam int DEF_MAX_VALUE  = 65535;
    localparam int DEF_MAX_PRIMES = 8192;

    // Field widths
    localparam int VALUE_W = 16;
    localparam int COUNT_W = 4;
    localparam int TOTAL_W = 14;
    localparam int LIMIT_W = 16;

    // Saturation point of the reported prime total
    localparam int TOTAL_CAP = 16383;

    // Reset value of the limit register
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'hFFFF;

    // Operation codes
    localparam logic OP_BUILD = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Register index carried in paddr[2]
    localparam logic REG_SIEVE_LIMIT = 1'b0;

    typedef struct packed {
        logic               operation;
        logic [VALUE_W-1:0] query_value;
    } t_cmd;

    typedef struct packed {
        logic [COUNT_W-1:0] factor_count;
        logic               is_composite;
        logic               invalid;
        logic [TOTAL_W-1:0] primes_found;
    } t_result;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_RD_I,
        ST_CHK_I,
        ST_RD_P,
        ST_MUL,
        ST_CMP,
        ST_DIV,
        ST_WR,
        ST_NEXT_I,
        ST_FINISH,
        ST_QRES
    } t_state;

endpackage

`default_nettype wire

FILE: hdl/linear_sieve_prime_factor_count.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Ports                                   | Transfer
// ---------+-----------------------------------------+------------------------------------
// command  | start, busy, i_cmd                      | edge with start high and busy low
// result   | o_done, o_result                        | edge that ends the o_done cycle
// config   | psel, penable, pwrite, paddr, pwdata,   | edge with psel, penable, pwrite,
//          | prdata, pready                          | pready high
//
// A query passes one table read and one output register between its transfer and o_done.
// A build clears entries 0..limit, then walks i = 2..limit; each (i, prime) pair within the
// limit is marked after the bit-serial remainder unit (VW = bits of MAX_VALUE) tests i mod p,
// a pair past the limit or running off the prime list moves on to the next i, and a closing
// state precedes o_done. i_rst_n is synchronous and leaves the tables unbuilt, so queries
// report invalid until a build; the receiver cannot stall results.

module linear_sieve_prime_factor_count #(
    parameter int MAX_VALUE  = lspfc_pkg::DEF_MAX_VALUE,
    parameter int MAX_PRIMES = lspfc_pkg::DEF_MAX_PRIMES
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    // command channel
    input  wire                       start,
    output logic                      busy,
    input  lspfc_pkg::t_cmd           i_cmd,
    // result channel
    output logic                      o_done,
    output lspfc_pkg::t_result        o_result,
    // configuration port
    input  wire                       psel,
    input  wire                       penable,
    input  wire                       pwrite,
    input  wire  [2:0]                paddr,
    input  wire  [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    import lspfc_pkg::*;

    localparam int VW    = $clog2(MAX_VALUE + 1);
    localparam int DEPTH = 2 ** VW;
    localparam int PW    = $clog2(MAX_PRIMES);
    localparam int TW    = $clog2(MAX_PRIMES + 1);
    localparam int BW    = $clog2(VW);
    localparam int EW    = TW + TOTAL_W;
    localparam int MW    = 2 * VW;

    // Control and datapath registers
    t_state               r_state, n_state;
    logic [LIMIT_W-1:0]   r_limit;
    logic                 r_built;
    logic [TW-1:0]        r_total;
    logic [VW-1:0]        r_addr;
    logic [VW-1:0]        r_i;
    logic [TW-1:0]        r_k;
    logic [COUNT_W-1:0]   r_ci;
    logic [VW-1:0]        r_p;
    logic [MW-1:0]        r_m;
    logic [VW-1:0]        r_rem;
    logic [BW-1:0]        r_bit;
    logic                 r_q_inval;
    logic                 r_done;
    t_result              r_result;

    // Memories: {composite, count} per value, and the prime list
    logic [COUNT_W:0]     r_tbl_mem [DEPTH];
    logic [COUNT_W:0]     r_tbl_rd;
    logic [VW-1:0]        r_plist_mem [2 ** PW];
    logic [VW-1:0]        r_plist_rd;

    // Memory port controls
    logic                 w_tbl_we;
    logic [VW-1:0]        w_tbl_waddr;
    logic [COUNT_W:0]     w_tbl_wdata;
    logic [VW-1:0]        w_tbl_raddr;
    logic                 w_plist_we;
    logic                 w_plist_re;

    // Derived values
    logic [VW-1:0]        w_lim;
    logic                 w_cfg_wr;
    logic                 w_accept;
    logic                 w_q_over;
    logic [VW:0]          w_trial;
    logic [VW-1:0]        w_rem_next;
    logic [EW-1:0]        w_total_ext;
    logic [TOTAL_W-1:0]   w_total_sat;
    logic [COUNT_W-1:0]   w_cnt_i;

    // Active limit: smaller of the register and MAX_VALUE
    assign w_lim = (32'(r_limit) > 32'(MAX_VALUE)) ? VW'(MAX_VALUE) : VW'(r_limit);

    assign w_accept = start && (r_state == ST_IDLE);
    assign busy     = (r_state != ST_IDLE);
    assign w_q_over = 32'(i_cmd.query_value) > 32'(w_lim);

    // Config port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr[2] == REG_SIEVE_LIMIT);
    assign prdata   = (paddr[2] == REG_SIEVE_LIMIT) ? 32'(r_limit) : 32'd0;

    // One restoring step of i mod p
    assign w_trial    = {r_rem, r_i[r_bit]};
    assign w_rem_next = (w_trial >= {1'b0, r_p}) ? VW'(w_trial - {1'b0, r_p})
                                                  : VW'(w_trial);

    // Saturate the reported total
    assign w_total_ext = EW'(r_total);
    assign w_total_sat = (w_total_ext > EW'(TOTAL_CAP)) ? TOTAL_W'(TOTAL_CAP)
                                                         : TOTAL_W'(r_total);

    // Count of i, with a prime starting at one factor
    assign w_cnt_i = (r_tbl_rd[COUNT_W-1:0] == '0) ? COUNT_W'(1) : r_tbl_rd[COUNT_W-1:0];

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = (i_cmd.operation == OP_BUILD) ? ST_CLEAR : ST_QRES;
                end
            end
            ST_CLEAR: begin
                if (r_addr == w_lim) begin
                    n_state = (w_lim < VW'(2)) ? ST_FINISH : ST_RD_I;
                end
            end
            ST_RD_I:   n_state = ST_CHK_I;
            ST_CHK_I:  n_state = ST_RD_P;
            ST_RD_P:   n_state = (r_k < r_total) ? ST_MUL : ST_NEXT_I;
            ST_MUL:    n_state = ST_CMP;
            ST_CMP:    n_state = (r_m > MW'(w_lim)) ? ST_NEXT_I : ST_DIV;
            ST_DIV:    n_state = (r_bit == '0) ? ST_WR : ST_DIV;
            ST_WR:     n_state = (r_rem == '0) ? ST_NEXT_I : ST_RD_P;
            ST_NEXT_I: n_state = (r_i == w_lim) ? ST_FINISH : ST_RD_I;
            ST_FINISH: n_state = ST_IDLE;
            ST_QRES:   n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Memory port controls per state
    always_comb begin
        w_tbl_we    = 1'b0;
        w_tbl_waddr = r_addr;
        w_tbl_wdata = '0;
        w_tbl_raddr = r_i;
        w_plist_we  = 1'b0;
        w_plist_re  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                w_tbl_raddr = VW'(i_cmd.query_value);
            end
            ST_CLEAR: begin
                w_tbl_we = 1'b1;
            end
            ST_CHK_I: begin
                w_plist_we = !r_tbl_rd[COUNT_W] && (r_total < TW'(MAX_PRIMES));
            end
            ST_RD_P: begin
                w_plist_re = 1'b1;
            end
            ST_WR: begin
                w_tbl_we    = 1'b1;
                w_tbl_waddr = r_m[VW-1:0];
                w_tbl_wdata = {1'b1, (r_rem == '0) ? r_ci : COUNT_W'(r_ci + COUNT_W'(1))};
            end
            default: begin
            end
        endcase
    end

    // State and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_limit <= LIMIT_RESET;
            r_built <= 1'b0;
            r_total <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == ST_FINISH) || (r_state == ST_QRES);
            if (w_cfg_wr) begin
                r_limit <= pwdata[LIMIT_W-1:0];
                r_built <= 1'b0;
            end else if (r_state == ST_FINISH) begin
                r_built <= 1'b1;
            end
            if (w_accept && (i_cmd.operation == OP_BUILD)) begin
                r_total <= '0;
            end else if (w_plist_we) begin
                r_total <= TW'(r_total + TW'(1));
            end
        end
    end

    // Sieve datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_addr    <= '0;
                r_q_inval <= !r_built || w_q_over;
            end
            ST_CLEAR: begin
                r_addr <= VW'(r_addr + VW'(1));
                r_i    <= VW'(2);
            end
            ST_CHK_I: begin
                r_ci <= w_cnt_i;
                r_k  <= '0;
            end
            ST_MUL: begin
                r_m <= MW'(r_i) * MW'(r_plist_rd);
                r_p <= r_plist_rd;
            end
            ST_CMP: begin
                r_rem <= '0;
                r_bit <= BW'(VW - 1);
            end
            ST_DIV: begin
                r_rem <= w_rem_next;
                r_bit <= BW'(r_bit - BW'(1));
            end
            ST_WR: begin
                r_k <= TW'(r_k + TW'(1));
            end
            ST_NEXT_I: begin
                r_i <= VW'(r_i + VW'(1));
            end
            default: begin
            end
        endcase
    end

    // Value table: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (w_tbl_we) begin
            r_tbl_mem[w_tbl_waddr] <= w_tbl_wdata;
        end
        r_tbl_rd <= r_tbl_mem[w_tbl_raddr];
    end

    // Prime list: append at the total, read at k
    always_ff @(posedge i_clk) begin
        if (w_plist_we) begin
            r_plist_mem[r_total[PW-1:0]] <= r_i;
        end
        if (w_plist_re) begin
            r_plist_rd <= r_plist_mem[r_k[PW-1:0]];
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        r_result.primes_found <= w_total_sat;
        if (r_state == ST_QRES && !r_q_inval) begin
            r_result.factor_count <= r_tbl_rd[COUNT_W-1:0];
            r_result.is_composite <= r_tbl_rd[COUNT_W];
            r_result.invalid      <= 1'b0;
        end else begin
            r_result.factor_count <= '0;
            r_result.is_composite <= 1'b0;
            r_result.invalid      <= (r_state == ST_QRES);
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import lspfc_pkg::*;

    localparam int WATCHDOG_CYCLES = 1_000_000;
    localparam int RANDOM_ITEMS    = 1350;
    localparam int DIRECTED_ITEMS  = 20;
    localparam int MAX_VAL         = DEF_MAX_VALUE;
    localparam int MAX_PRM         = DEF_MAX_PRIMES;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start   = 1'b0;
    logic        busy;
    t_cmd        i_cmd   = '0;
    logic        o_done;
    t_result     o_result;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    linear_sieve_prime_factor_count dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .o_done   (o_done),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Mirror of the sieve tables
    bit               marked      [0:MAX_VAL];
    bit [COUNT_W-1:0] dist_primes [0:MAX_VAL];
    int unsigned      prime_tab   [0:MAX_PRM-1];
    int unsigned      prime_cnt    = 0;
    bit               tables_ready = 1'b0;
    int unsigned      limit_reg    = LIMIT_RESET;

    t_cmd        cmd_backlog[$];
    t_result     exp_answers[$];
    logic        cmd_taken     = 1'b0;
    int unsigned gap_left      = 0;
    bit          no_gaps       = 1'b0;
    int unsigned items_queued  = 0;
    int unsigned idle_cycles   = 0;
    int unsigned errors        = 0;
    int unsigned n_builds      = 0;
    int unsigned n_queries     = 0;
    int unsigned n_invalid     = 0;
    int unsigned n_writes      = 0;
    int unsigned largest_built = 0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic int unsigned active_limit();
        return (limit_reg > MAX_VAL) ? MAX_VAL : limit_reg;
    endfunction

    // Rebuild the mirror tables with a linear sieve up to the active limit
    function automatic void run_sieve();
        int unsigned      lim;
        int unsigned      p;
        longint unsigned  m;
        bit [COUNT_W-1:0] c;
        lim = active_limit();
        for (int n = 0; n <= MAX_VAL; n++) begin
            marked[n]      = 1'b0;
            dist_primes[n] = '0;
        end
        prime_cnt = 0;
        for (int unsigned i = 2; i <= lim; i++) begin
            if (!marked[i] && prime_cnt < MAX_PRM) begin
                prime_tab[prime_cnt] = i;
                prime_cnt++;
            end
            for (int unsigned k = 0; k < prime_cnt; k++) begin
                p = prime_tab[k];
                m = longint'(i) * longint'(p);
                if (m > lim) break;
                marked[m] = 1'b1;
                c = dist_primes[i];
                // a prime i contributes one factor of its own
                if (c == 0) c = 1;
                if (i % p == 0) begin
                    dist_primes[m] = c;
                    break;
                end
                dist_primes[m] = c + 1'b1;
            end
        end
        tables_ready = 1'b1;
    endfunction

    function automatic t_result predict_answer(t_cmd c);
        t_result     r;
        int unsigned lim;
        r   = '0;
        lim = active_limit();
        if (c.operation == OP_BUILD) begin
            run_sieve();
            n_builds++;
            if (lim > largest_built) largest_built = lim;
        end else begin
            n_queries++;
            if (!tables_ready || c.query_value > lim) begin
                r.invalid = 1'b1;
                n_invalid++;
            end else begin
                r.factor_count = dist_primes[c.query_value];
                r.is_composite = marked[c.query_value];
            end
        end
        r.primes_found = (prime_cnt > TOTAL_CAP) ? TOTAL_W'(TOTAL_CAP) : TOTAL_W'(prime_cnt);
        return r;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(30, 150);
    endfunction

    // Mostly small limits keep the sieve walk short
    function automatic int unsigned pick_limit();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10) return $urandom_range(2, 16);
        if (r < 75) return $urandom_range(17, 400);
        if (r < 95) return $urandom_range(401, 1200);
        return $urandom_range(1201, 3000);
    endfunction

    function automatic int unsigned pick_value(int unsigned lim);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 6) begin
            case ($urandom_range(0, 3))
                0:       return 0;
                1:       return 1;
                2:       return lim;
                default: return (lim < 65535) ? lim + 1 : lim;
            endcase
        end
        if (r < 72) return $urandom_range(0, lim);
        if (r < 86 && lim < 65535) return $urandom_range(lim + 1, 65535);
        return $urandom_range(0, 65535);
    endfunction

    task automatic push_query(int unsigned v);
        t_cmd c;
        c.operation   = OP_QUERY;
        c.query_value = v[VALUE_W-1:0];
        cmd_backlog.insert(cmd_backlog.size(), c);
        items_queued++;
    endtask

    task automatic push_build(int unsigned v);
        t_cmd c;
        c.operation   = OP_BUILD;
        c.query_value = v[VALUE_W-1:0];
        cmd_backlog.insert(cmd_backlog.size(), c);
        items_queued++;
    endtask

    // Hold until every queued command has been transferred and answered
    task automatic wait_idle();
        do @(posedge i_clk);
        while (cmd_backlog.size() != 0 || start || exp_answers.size() != 0 || busy);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_limit(int unsigned v);
        wait_idle();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_SIEVE_LIMIT, 2'b00};
        pwdata  <= {16'h0000, v[LIMIT_W-1:0]};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        limit_reg    = v[LIMIT_W-1:0];
        tables_ready = 1'b0;
        n_writes++;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // Command driver: present the next item, hold it until transferred
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start    <= 1'b0;
            gap_left <= 0;
        end else if (!(start && !cmd_taken)) begin
            if (gap_left != 0) begin
                start    <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (cmd_backlog.size() != 0) begin
                start    <= 1'b1;
                i_cmd    <= cmd_backlog.pop_front();
                gap_left <= pick_gap();
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: predict on each command transfer, check each result
    always @(posedge i_clk) begin
        t_result want;
        cmd_taken <= start && !busy && i_rst_n;
        if (i_rst_n) begin
            if (start && !busy) exp_answers.insert(exp_answers.size(), predict_answer(i_cmd));
            if (o_done) begin
                if (exp_answers.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, got %0d %0d %0d %0d",
                             $time, o_result.factor_count, o_result.is_composite,
                             o_result.invalid, o_result.primes_found);
                    errors++;
                end else begin
                    want = exp_answers.pop_front();
                    check_field("factor_count", want.factor_count, o_result.factor_count);
                    check_field("is_composite", want.is_composite, o_result.is_composite);
                    check_field("invalid", want.invalid, o_result.invalid);
                    check_field("primes_found", want.primes_found, o_result.primes_found);
                end
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done || (psel && penable && pwrite && pready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles + 1 >= WATCHDOG_CYCLES) begin
                $display("%0t ns: no transfer for %0d cycles", $time, WATCHDOG_CYCLES);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        int unsigned lim;
        int unsigned nq;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Queries before any build answer invalid
        push_query(0);
        push_query(16'hFFFF);
        push_query(16'h5AA5);

        // Smallest limit: one prime, 0 and 1 valid, above limit invalid
        write_limit(2);
        push_build(16'hFFFF);
        push_query(0);
        push_query(1);
        push_query(2);
        push_query(3);

        // Prime powers, products of two and three primes, rebuild
        write_limit(30);
        push_build(0);
        push_query(4);
        push_query(6);
        push_query(30);
        push_query(29);
        push_query(31);
        push_build(16'h1234);
        push_query(30);

        // New limit drops the tables until the next build
        write_limit(210);
        push_query(210);
        push_build(16'hA5A5);
        push_query(210);
        push_query(128);

        // Random phases: new limit, mostly a build first, then queries
        for (int phase = 0; items_queued < DIRECTED_ITEMS + RANDOM_ITEMS; phase++) begin
            if (phase == 3) lim = 8191;
            else if (phase == 8) lim = 65535;
            else lim = pick_limit();
            write_limit(lim);
            no_gaps = ($urandom_range(0, 3) == 0);
            if (lim <= 8191 && $urandom_range(0, 7) != 0) push_build($urandom_range(0, 65535));
            nq = $urandom_range(20, 80);
            repeat (nq) begin
                if (lim <= 3000 && $urandom_range(0, 39) == 0)
                    push_build($urandom_range(0, 65535));
                push_query(pick_value(lim));
            end
        end

        wait_idle();
        repeat (10) @(posedge i_clk);

        $display("Covered %0d builds (largest limit %0d) and %0d queries, %0d answered invalid,",
                 n_builds, largest_built, n_queries, n_invalid);
        $display("over %0d limit writes; %0d mismatches", n_writes, errors);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
